// ----- rtl/pfse_pkg.sv -----
`timescale 1ns / 1ps
// Package for the Playfair stream encryptor: key square types, letter codes,
// ASCII constants and the reset contents of the key square. No dependencies.
package pfse_pkg;

  localparam int unsigned SqSize = 5;
  localparam int unsigned CodeW  = 5;
  localparam int unsigned RowW   = SqSize * CodeW;
  localparam int unsigned IdxW   = 3;
  localparam int unsigned CharW  = 8;
  localparam int unsigned OutW   = 7;

  typedef logic [IdxW-1:0]  sq_idx_t;
  typedef logic [CodeW-1:0] code_t;
  typedef logic [SqSize-1:0][CodeW-1:0] key_row_t;
  typedef key_row_t [SqSize-1:0] key_sq_t;

  localparam code_t CodeI   = 5'd8;
  localparam code_t CodeJ   = 5'd9;
  localparam code_t CodeX   = 5'd23;
  localparam code_t CodeMax = 5'd25;

  localparam logic [CharW-1:0] AsciiUpA = 8'd65;
  localparam logic [CharW-1:0] AsciiUpZ = 8'd90;
  localparam logic [CharW-1:0] AsciiLoA = 8'd97;
  localparam logic [CharW-1:0] AsciiLoZ = 8'd122;
  localparam logic [OutW-1:0]  OutA     = 7'd65;
  localparam logic [OutW-1:0]  OutZ     = 7'd90;

  localparam logic [RowW-1:0] KeyReset [SqSize] = '{
    25'd10755244, 25'd17283508, 25'd25942713, 25'd6848868, 25'd2149955
  };

  function automatic code_t fold_j(code_t c);
    return (c == CodeJ) ? CodeI : c;
  endfunction

  function automatic sq_idx_t inc5(sq_idx_t v);
    return (v == sq_idx_t'(SqSize - 1)) ? '0 : sq_idx_t'(v + 1'b1);
  endfunction

  function automatic logic [OutW-1:0] to_ascii(code_t c);
    return (c > CodeMax) ? OutZ : OutA + {2'b00, c};
  endfunction

endpackage

// ----- rtl/pfse_pair_enc.sv -----
`timescale 1ns / 1ps
// Combinational Playfair encryption of one letter pair over the key square.
// Depends on pfse_pkg.
module pfse_pair_enc (
  input  pfse_pkg::key_sq_t        key_i,
  input  pfse_pkg::code_t          a_i,
  input  pfse_pkg::code_t          b_i,
  output logic [pfse_pkg::OutW-1:0] x_o,
  output logic [pfse_pkg::OutW-1:0] y_o
);
  import pfse_pkg::*;

  sq_idx_t r1, c1, r2, c2;
  code_t   x_code, y_code;

  // Scan from the far end so that the first match in row-major order wins.
  // A letter not found sits at row 0, column 0.
  always_comb begin
    r1 = '0;
    c1 = '0;
    r2 = '0;
    c2 = '0;
    for (int r = SqSize - 1; r >= 0; r--) begin
      for (int c = SqSize - 1; c >= 0; c--) begin
        if (fold_j(key_i[r][c]) == a_i) begin
          r1 = sq_idx_t'(r);
          c1 = sq_idx_t'(c);
        end
        if (fold_j(key_i[r][c]) == b_i) begin
          r2 = sq_idx_t'(r);
          c2 = sq_idx_t'(c);
        end
      end
    end
  end

  always_comb begin
    if (r1 == r2) begin
      x_code = key_i[r1][inc5(c1)];
      y_code = key_i[r2][inc5(c2)];
    end else if (c1 == c2) begin
      x_code = key_i[inc5(r1)][c1];
      y_code = key_i[inc5(r2)][c2];
    end else begin
      x_code = key_i[r1][c2];
      y_code = key_i[r2][c1];
    end
  end

  assign x_o = to_ascii(x_code);
  assign y_o = to_ascii(y_code);

endmodule

// ----- rtl/playfair_stream_encryptor_top.sv -----
`timescale 1ns / 1ps
// Playfair stream encryptor top level. A byte sits in the input register
// until the output buffer has room; its cipher letters are then registered
// into the buffer and offered from there. Throughput: one byte per cycle
// while no letters are pending; letters stream at one per cycle while
// out_stall_i is low. Reset clears the handshake state and the held letter
// and loads the default key square. Depends on pfse_pkg and pfse_pair_enc.
module playfair_stream_encryptor_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  pfse_pkg::sq_idx_t             cfg_idx_i,
  input  logic [pfse_pkg::RowW-1:0]     cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [pfse_pkg::CharW-1:0]    char_in_i,
  input  logic                          msg_end_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [pfse_pkg::OutW-1:0]     cipher_char_o,
  output logic                          run_last_o
);
  import pfse_pkg::*;

  key_sq_t key_q;

  logic             in_v_q;
  logic [CharW-1:0] ch_q;
  logic             end_q;

  logic  held_v_q, held_v_d;
  code_t held_q, held_d;

  logic [OutW-1:0] buf_q [4];
  logic [2:0]      rem_q;
  logic [1:0]      rd_q;

  logic       in_acc, out_acc, buf_free, adv;
  logic       is_letter;
  code_t      code;
  logic       p1, p2, mid_v;
  code_t      a0, b0, a1, b1;
  logic [2:0] n_res;
  logic [OutW-1:0] x0, y0, x1, y1;

  // Key square registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < SqSize; r++) begin
        key_q[r] <= KeyReset[r];
      end
    end else if (cfg_we_i) begin
      for (int r = 0; r < SqSize; r++) begin
        if (cfg_idx_i == sq_idx_t'(r)) begin
          key_q[r] <= cfg_data_i;
        end
      end
    end
  end

  assign out_acc    = out_valid_o & ~out_stall_i;
  assign buf_free   = (rem_q == 3'd0) || ((rem_q == 3'd1) && !out_stall_i);
  assign adv        = in_v_q & buf_free;
  assign in_stall_o = in_v_q & ~adv;
  assign in_acc     = in_valid_i & ~in_stall_o;

  // Letter decode with case folding and J mapped to I.
  always_comb begin
    is_letter = 1'b0;
    code      = '0;
    if (ch_q inside {[AsciiUpA:AsciiUpZ]}) begin
      is_letter = 1'b1;
      code      = code_t'(ch_q - AsciiUpA);
    end else if (ch_q inside {[AsciiLoA:AsciiLoZ]}) begin
      is_letter = 1'b1;
      code      = code_t'(ch_q - AsciiLoA);
    end
    code = fold_j(code);
  end

  // Pair forming. A doubled letter pairs with X and stays held; at message
  // end a letter still held pairs with X.
  always_comb begin
    p1     = is_letter & held_v_q;
    held_d = held_q;
    mid_v  = held_v_q;
    if (is_letter) begin
      if (!held_v_q) begin
        held_d = code;
        mid_v  = 1'b1;
      end else if (held_q != code) begin
        mid_v = 1'b0;
      end
    end
    p2       = end_q & mid_v;
    held_v_d = mid_v & ~end_q;
    if (p1) begin
      a0 = held_q;
      b0 = (held_q == code) ? CodeX : code;
    end else begin
      a0 = held_d;
      b0 = CodeX;
    end
    a1    = held_d;
    b1    = CodeX;
    n_res = {p1 & p2, p1 ^ p2, 1'b0};
  end

  pfse_pair_enc u_enc0 (
    .key_i (key_q),
    .a_i   (a0),
    .b_i   (b0),
    .x_o   (x0),
    .y_o   (y0)
  );

  pfse_pair_enc u_enc1 (
    .key_i (key_q),
    .a_i   (a1),
    .b_i   (b1),
    .x_o   (x1),
    .y_o   (y1)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q   <= 1'b0;
      held_v_q <= 1'b0;
      held_q   <= '0;
      rem_q    <= '0;
      rd_q     <= '0;
    end else begin
      if (in_acc) begin
        in_v_q <= 1'b1;
      end else if (adv) begin
        in_v_q <= 1'b0;
      end
      if (adv) begin
        held_v_q <= held_v_d;
        held_q   <= held_d;
        rem_q    <= n_res;
        rd_q     <= '0;
      end else if (out_acc) begin
        rem_q <= rem_q - 3'd1;
        rd_q  <= rd_q + 2'd1;
      end
    end
  end

  // Payload registers need no reset.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      ch_q  <= char_in_i;
      end_q <= msg_end_i;
    end
    if (adv) begin
      buf_q[0] <= x0;
      buf_q[1] <= y0;
      buf_q[2] <= x1;
      buf_q[3] <= y1;
    end
  end

  assign out_valid_o   = (rem_q != 3'd0);
  assign cipher_char_o = buf_q[rd_q];
  assign run_last_o    = (rem_q == 3'd1);

endmodule
